@@ design/csem_pkg.sv @@
// ----------------------------------------------------------------------------
// Semaphore wait queue package
// Shared widths, operation and status codes, and word types.
// ----------------------------------------------------------------------------
`default_nettype none

package csem_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned TASK_W  = 6;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned TOKEN_W = 16;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PEND    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_DELETE  = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_UNAVAIL = 2'd1,
    ST_WAITING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [TASK_W-1:0] tid;
    logic [PRIO_W-1:0] prio;
  } wq_entry_t;

  typedef struct packed {
    status_e           status;
    logic              woken_valid;
    logic [TASK_W-1:0] woken_task;
    logic              preempt;
    logic              last;
  } rsp_word_t;

  localparam rsp_word_t RSP_DONE = '{
    status:      ST_OK,
    woken_valid: 1'b0,
    woken_task:  '0,
    preempt:     1'b0,
    last:        1'b1
  };

endpackage

`default_nettype wire

@@ design/csem_if.sv @@
// ----------------------------------------------------------------------------
// Semaphore wait queue channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface csem_req_if import csem_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [TASK_W-1:0] task_id;
  logic [PRIO_W-1:0] task_priority;
  logic              no_wait;

  modport source (output valid, operation, task_id, task_priority, no_wait, input ready);
  modport sink (input valid, operation, task_id, task_priority, no_wait, output ready);
endinterface

interface csem_rsp_if import csem_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              woken_valid;
  logic [TASK_W-1:0] woken_task;
  logic              preempt;
  logic              last;

  modport source (output valid, status, woken_valid, woken_task, preempt, last, input ready);
  modport sink (input valid, status, woken_valid, woken_task, preempt, last, output ready);
endinterface

interface csem_cfg_if import csem_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOKEN_W-1:0] initial_tokens;

  modport source (output valid, initial_tokens, input ready);
  modport sink (input valid, initial_tokens, output ready);
endinterface

`default_nettype wire

@@ design/csem_wq_mem.sv @@
// ----------------------------------------------------------------------------
// Semaphore wait queue storage
// Wait list entries with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module csem_wq_mem import csem_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic           clk_i,
  input  wire logic           wr_en_i,
  input  wire logic [AW-1:0]  wr_addr_i,
  input  wire wq_entry_t      wr_data_i,
  input  wire logic           rd_en_i,
  input  wire logic [AW-1:0]  rd_addr_i,
  output wq_entry_t           rd_data_o
);

  wq_entry_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/csem_unit.sv @@
// ----------------------------------------------------------------------------
// Semaphore wait queue shared unit
// Circular list address from head and offset, and one priority compare.
// ----------------------------------------------------------------------------
`default_nettype none

module csem_unit import csem_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  wire logic [AW-1:0]     head_i,
  input  wire logic [CW-1:0]     off_i,
  input  wire logic [PRIO_W-1:0] a_i,
  input  wire logic [PRIO_W-1:0] b_i,
  output logic [AW-1:0]          addr_o,
  output logic                   gt_o
);

  localparam int unsigned SW = AW + 1;

  logic [SW-1:0] sum;

  always_comb begin
    sum = SW'(head_i) + SW'(off_i);
    if (sum >= SW'(DEPTH)) begin
      addr_o = AW'(sum - SW'(DEPTH));
    end else begin
      addr_o = AW'(sum);
    end
    gt_o = a_i > b_i;
  end

endmodule

`default_nettype wire

@@ design/counting_semaphore_priority_waitq_unit.sv @@
// ----------------------------------------------------------------------------
// Counting semaphore with priority wait queue
// Flow: a request is executed, then its response word is loaded in the emit state;
// a waking release first passes a compare state, an insert a compare and a read
// state per waiter moved. A delete loads each word in its output state, reading the
// next in between; the request side is ready again once the last word is loaded.
// Reset: token count zero, wait list empty; list storage is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_priority_waitq_unit import csem_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned MAX_TASKS   = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  csem_req_if.sink   req_i,
  csem_rsp_if.source rsp_o,
  csem_cfg_if.sink   cfg_i
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_REL_CMP,
    S_DEL_RD,
    S_DEL_OUT,
    S_EMIT
  } state_e;

  function automatic logic [TASK_W-1:0] reduce_tid(input logic [TASK_W-1:0] v);
    int r;
    r = int'(v);
    for (int k = TASK_W - 1; k >= 0; k--) begin
      if (r >= (MAX_TASKS << k)) begin
        r = r - (MAX_TASKS << k);
      end
    end
    return TASK_W'(r);
  endfunction

  function automatic rsp_word_t done_word(input status_e st);
    rsp_word_t w;
    w        = RSP_DONE;
    w.status = st;
    return w;
  endfunction

  state_e             state_q;
  logic [OP_W-1:0]    op_q;
  logic [TASK_W-1:0]  tid_q;
  logic [PRIO_W-1:0]  prio_q;
  logic               nowait_q;
  logic [TOKEN_W-1:0] token_q;
  logic [CW-1:0]      count_q;
  logic [AW-1:0]      head_q;
  logic [CW-1:0]      idx_q;
  rsp_word_t          res_q;
  rsp_word_t          rsp_q;
  logic               rsp_valid_q;

  logic          out_free;
  logic          rsp_load;
  logic          list_full;
  logic          pend_waits;
  logic          del_last;
  logic [CW-1:0] off;
  logic [PRIO_W-1:0] cmp_a;
  logic [PRIO_W-1:0] cmp_b;
  logic [AW-1:0] unit_addr;
  logic          unit_gt;
  logic          mem_we;
  logic          mem_re;
  wq_entry_t     mem_wdata;
  wq_entry_t     mem_rdata;

  assign req_i.ready       = (state_q == S_IDLE);
  assign cfg_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_q.status;
  assign rsp_o.woken_valid = rsp_q.woken_valid;
  assign rsp_o.woken_task  = rsp_q.woken_task;
  assign rsp_o.preempt     = rsp_q.preempt;
  assign rsp_o.last        = rsp_q.last;

  assign out_free   = !rsp_valid_q || rsp_o.ready;
  assign rsp_load   = out_free && ((state_q == S_EMIT) || (state_q == S_DEL_OUT));
  assign list_full  = (count_q == CW'(QUEUE_DEPTH));
  assign pend_waits = (token_q == '0) && !nowait_q && !list_full;
  assign del_last   = ((idx_q + CW'(1)) == count_q);

  always_comb begin
    off       = '0;
    cmp_a     = mem_rdata.prio;
    cmp_b     = prio_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = '{tid: tid_q, prio: prio_q};
    case (state_q)
      S_EXEC: begin
        if (op_q == OP_PEND) begin
          off    = count_q - CW'(1);
          mem_re = pend_waits && (count_q != '0);
        end else begin
          mem_re = (count_q != '0) && ((op_q == OP_RELEASE) || (op_q == OP_DELETE));
        end
      end
      S_INS_RD: begin
        off    = idx_q - CW'(1);
        mem_re = 1'b1;
      end
      S_INS_CMP: begin
        off    = idx_q;
        mem_we = 1'b1;
        if (unit_gt) begin
          mem_wdata = mem_rdata;
        end
      end
      S_INS_PUT: begin
        off    = idx_q;
        mem_we = 1'b1;
      end
      S_REL_CMP: begin
        off   = CW'(1);
        cmp_a = prio_q;
        cmp_b = mem_rdata.prio;
      end
      S_DEL_RD: begin
        off    = idx_q;
        mem_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  csem_unit #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_unit (
    .head_i (head_q),
    .off_i  (off),
    .a_i    (cmp_a),
    .b_i    (cmp_b),
    .addr_o (unit_addr),
    .gt_o   (unit_gt)
  );

  csem_wq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (unit_addr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (unit_addr),
    .rd_data_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      tid_q       <= '0;
      prio_q      <= '0;
      nowait_q    <= 1'b0;
      token_q     <= '0;
      count_q     <= '0;
      head_q      <= '0;
      idx_q       <= '0;
      res_q       <= RSP_DONE;
      rsp_q       <= RSP_DONE;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_o.ready && !rsp_load) begin
        rsp_valid_q <= 1'b0;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        token_q <= cfg_i.initial_tokens;
        count_q <= '0;
        head_q  <= '0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            op_q     <= req_i.operation;
            tid_q    <= reduce_tid(req_i.task_id);
            prio_q   <= req_i.task_priority;
            nowait_q <= req_i.no_wait;
            state_q  <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op_q)
            OP_PEND: begin
              if (token_q != '0) begin
                token_q <= token_q - TOKEN_W'(1);
                res_q   <= RSP_DONE;
                state_q <= S_EMIT;
              end else if (nowait_q) begin
                res_q   <= done_word(ST_UNAVAIL);
                state_q <= S_EMIT;
              end else if (list_full) begin
                res_q   <= done_word(ST_FULL);
                state_q <= S_EMIT;
              end else if (count_q == '0) begin
                idx_q   <= '0;
                state_q <= S_INS_PUT;
              end else begin
                idx_q   <= count_q;
                state_q <= S_INS_CMP;
              end
            end
            OP_RELEASE: begin
              if (count_q != '0) begin
                state_q <= S_REL_CMP;
              end else begin
                if (token_q != '1) begin
                  token_q <= token_q + TOKEN_W'(1);
                end
                res_q   <= RSP_DONE;
                state_q <= S_EMIT;
              end
            end
            OP_DELETE: begin
              token_q <= '0;
              if (count_q != '0) begin
                idx_q   <= '0;
                state_q <= S_DEL_OUT;
              end else begin
                res_q   <= RSP_DONE;
                state_q <= S_EMIT;
              end
            end
            default: begin
              res_q   <= RSP_DONE;
              state_q <= S_EMIT;
            end
          endcase
        end
        S_INS_RD: begin
          state_q <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (unit_gt) begin
            idx_q <= idx_q - CW'(1);
            if (idx_q == CW'(1)) begin
              state_q <= S_INS_PUT;
            end else begin
              state_q <= S_INS_RD;
            end
          end else begin
            count_q <= count_q + CW'(1);
            res_q   <= done_word(ST_WAITING);
            state_q <= S_EMIT;
          end
        end
        S_INS_PUT: begin
          count_q <= count_q + CW'(1);
          res_q   <= done_word(ST_WAITING);
          state_q <= S_EMIT;
        end
        S_REL_CMP: begin
          head_q  <= unit_addr;
          count_q <= count_q - CW'(1);
          res_q   <= '{status: ST_OK, woken_valid: 1'b1, woken_task: mem_rdata.tid,
                       preempt: unit_gt, last: 1'b1};
          state_q <= S_EMIT;
        end
        S_DEL_RD: begin
          state_q <= S_DEL_OUT;
        end
        S_DEL_OUT: begin
          if (out_free) begin
            rsp_q       <= '{status: ST_OK, woken_valid: 1'b1, woken_task: mem_rdata.tid,
                             preempt: 1'b0, last: del_last};
            rsp_valid_q <= 1'b1;
            if (del_last) begin
              count_q <= '0;
              head_q  <= '0;
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + CW'(1);
              state_q <= S_DEL_RD;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            rsp_q       <= res_q;
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("wait list count exceeds its depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ((count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1)) ||
       (count_q == '0)))
    else $error("wait list count moved by more than one entry");

  a_woken_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.woken_valid) |-> (rsp_q.status == ST_OK))
    else $error("woken task reported with a failing status");

  a_del_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL_OUT) |-> ((count_q != '0) && (idx_q < count_q)))
    else $error("delete drain runs past the wait list");

endmodule

`default_nettype wire
